// ===== rtl/core/bfpa_pkg.sv =====
`default_nettype none
package bfpa_pkg;

  localparam int PAGE_COUNT = 8192;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int INDEX_W    = 13;
  localparam int LIMIT_W    = 14;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(8191);

  // Word 0 after reset: null page, bitmap page and the three kernel pages.
  localparam logic [WORD_BITS-1:0] INIT_WORD0 =
      (WORD_BITS'(1) << (32'h0000 >> 12)) |
      (WORD_BITS'(1) << (32'h6000 >> 12)) |
      (WORD_BITS'(1) << (32'h7c00 >> 12)) |
      (WORD_BITS'(1) << (32'h8000 >> 12)) |
      (WORD_BITS'(1) << (32'h9000 >> 12));

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfpa_bitmap.sv =====
`default_nettype none
module bfpa_bitmap
  import bfpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output logic      [WORD_BITS-1:0] rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_W-1:0]    wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] valid;
  logic [WORD_BITS-1:0]  mem_q;
  logic                  vld_q;
  logic                  zero_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // A word never written reads as its reset contents, so no clearing pass is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q  <= valid[rd_addr];
    zero_q <= (rd_addr == '0);
  end

  assign rd_data = vld_q ? mem_q : (zero_q ? INIT_WORD0 : '0);

endmodule
`default_nettype wire

// ===== rtl/core/bfpa_find.sv =====
`default_nettype none
module bfpa_find
  import bfpa_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic [ADDR_W-1:0]    addr,
  input  wire logic [LIMIT_W-1:0]   lim,
  output find_res_t                 res
);

  logic [LIMIT_W-1:0]   base;
  logic [LIMIT_W-1:0]   avail;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free;

  always_comb begin
    base  = LIMIT_W'({addr, BIT_W'(0)});
    avail = lim - base;
    // Pages at or above the limit count as used.
    if (avail >= LIMIT_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = (WORD_BITS'(1) << avail[BIT_W-1:0]) - WORD_BITS'(1);
    end
    free = ~word & mask;
    res.found   = 1'b0;
    res.bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free[i]) begin
        res.found   = 1'b1;
        res.bit_idx = BIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bitmap_first_fit_page_allocator.sv =====
`default_nettype none
// First-fit page frame allocator with one used bit per page, held as 64-bit words in
// an on-chip memory. An allocate beat (tuser 0) scans from page 0 for the lowest free
// page below page_limit, marks it used and returns it with ok set; a query beat
// (tuser 1) returns the page number and whether it is free. The scan reads one bitmap
// word per cycle through the memory's single read port, up to the word that holds page
// limit - 1, and the block takes no new beat while it works. The result sits in an
// output register, so a new beat is taken while it waits. After reset pages 0, 6, 7,
// 8 and 9 are used; per-word valid flags stand for the cleared store, so no clearing
// pass runs.
module bitmap_first_fit_page_allocator
  import bfpa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [LIMIT_W-1:0]   cfg_wdata,   // page_limit
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,     // [12:0] page_index, [15:13] zero
  input  wire logic                 s_tuser,     // req_type
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [15:0]          m_tdata,     // [12:0] page_index_out, [15:13] zero
  output logic                      m_tuser      // ok
);

  state_t               state, state_next;
  logic [LIMIT_W-1:0]   page_limit;
  logic [ADDR_W-1:0]    chk_addr, chk_addr_next;
  logic [BIT_W-1:0]     qbit, qbit_next;
  logic [INDEX_W-1:0]   res_idx, res_idx_next;
  logic                 res_ok, res_ok_next;
  logic [INDEX_W-1:0]   out_idx;

  logic [LIMIT_W-1:0]   lim;
  logic [LIMIT_W-1:0]   lim_m1;
  logic [ADDR_W-1:0]    last_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  find_res_t            fr;
  logic                 out_free;

  bfpa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (chk_addr),
    .wr_data (wr_data)
  );

  bfpa_find u_find (
    .word (rd_data),
    .addr (chk_addr),
    .lim  (lim),
    .res  (fr)
  );

  always_comb begin
    lim = (page_limit > LIMIT_W'(PAGE_COUNT)) ? LIMIT_W'(PAGE_COUNT) : page_limit;
  end

  assign lim_m1    = lim - LIMIT_W'(1);
  assign last_addr = lim_m1[INDEX_W-1:BIT_W];
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign wr_data   = rd_data | (WORD_BITS'(1) << fr.bit_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      page_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= chk_addr_next;
    qbit     <= qbit_next;
    res_idx  <= res_idx_next;
    res_ok   <= res_ok_next;
  end

  always_comb begin
    state_next    = state;
    chk_addr_next = chk_addr;
    qbit_next     = qbit;
    res_idx_next  = res_idx;
    res_ok_next   = res_ok;
    // While scanning, the read port runs one word ahead of the word being checked.
    rd_addr       = chk_addr + ADDR_W'(1);
    wr_en         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == REQ_QUERY) begin
            rd_addr      = s_tdata[INDEX_W-1:BIT_W];
            qbit_next    = s_tdata[BIT_W-1:0];
            res_idx_next = s_tdata[INDEX_W-1:0];
            state_next   = ST_QUERY;
          end else if (lim == '0) begin
            res_idx_next = '0;
            res_ok_next  = 1'b0;
            state_next   = ST_DONE;
          end else begin
            rd_addr       = '0;
            chk_addr_next = '0;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_QUERY: begin
        res_ok_next = ~rd_data[qbit];
        state_next  = ST_DONE;
      end
      ST_SCAN: begin
        if (fr.found) begin
          wr_en        = 1'b1;
          res_idx_next = {chk_addr, fr.bit_idx};
          res_ok_next  = 1'b1;
          state_next   = ST_DONE;
        end else if (chk_addr == last_addr) begin
          res_idx_next = '0;
          res_ok_next  = 1'b0;
          state_next   = ST_DONE;
        end else begin
          chk_addr_next = chk_addr + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_idx <= res_idx;
      m_tuser <= res_ok;
    end
  end

  assign m_tdata = 16'(out_idx);

endmodule
`default_nettype wire

// ===== rtl/core/bfpa_checker.sv =====
`default_nettype none
module bfpa_checker
  import bfpa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [15:0]        m_tdata,
  input wire logic               m_tuser
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a request was in progress");

  // A result only appears at the end of a request, never out of the idle state.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a request in progress");

  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:INDEX_W] == '0)
    else $error("padding bits of result data are not zero");

endmodule

bind bitmap_first_fit_page_allocator bfpa_checker u_bfpa_checker (.*);
`default_nettype wire
